// ===== rtl/mits_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mits_pkg
// Types and constants shared by the interval timer table modules.
// ----------------------------------------------------------------------------
package mits_pkg;

    localparam int MAX_TIMERS = 16;
    localparam int IDX_W      = $clog2(MAX_TIMERS);
    localparam int CNT_W      = $clog2(MAX_TIMERS + 1);
    localparam int IVL_W      = 32;
    localparam int JIF_W      = 64;

    localparam int CMD_DEPTH  = 2;
    localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);

    localparam int RES_DEPTH  = 4;
    localparam int RES_PTR_W  = $clog2(RES_DEPTH);
    localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);

    localparam logic       MODE_ADD     = 1'b0;
    localparam logic       MODE_TICK    = 1'b1;

    localparam logic [1:0] KIND_ADDED   = 2'd0;
    localparam logic [1:0] KIND_FULL    = 2'd1;
    localparam logic [1:0] KIND_EXPIRED = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_FULL,
        OP_TICK
    } t_op;

    typedef struct packed {
        logic             mode;
        logic [IVL_W-1:0] interval_ms;
        logic [JIF_W-1:0] jiffies;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] timer_index;
        logic       last;
    } t_out_item;

    // Classified request handed from the front part to the back part.
    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] index;
        logic [IVL_W-1:0] interval;
        logic [JIF_W-1:0] laps;
    } t_cmd;

endpackage
`default_nettype wire

// ===== rtl/multi_interval_timer_service.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_interval_timer_service
// Table of up to sixteen interval timers: adds timers and reports the ones
// that expire when a tick brings a new jiffies count.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake      Payload
//   request   in         push / full    i_in_item  (mode, interval_ms, jiffies)
//   result    out        pop / empty    o_out_item (kind, timer_index, last)
//
// The front takes one request per cycle, while it is not full, into a two-entry
// command queue. The scan engine answers an add or a full in its idle state; a
// tick starts the scan, visits each stored timer, sees the end of the table and
// then releases the final expiry.
// A slow result reader stalls the scan once the four-entry result queue fills.
// Synchronous active-low reset empties both queues and the timer table.
// ----------------------------------------------------------------------------
module multi_interval_timer_service (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire mits_pkg::t_in_item  i_in_item,
    output logic                     empty,
    input  wire logic                pop,
    output mits_pkg::t_out_item      o_out_item
);

    logic           cmd_valid;
    logic           cmd_pop;
    mits_pkg::t_cmd cmd;

    mits_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (i_in_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    mits_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

// ===== rtl/mits_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mits_front
// Accepts requests, assigns table slots, computes elapsed time and queues
// the classified commands for the scan engine.
// ----------------------------------------------------------------------------
module mits_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire mits_pkg::t_in_item i_in_item,
    output logic                   o_cmd_valid,
    output mits_pkg::t_cmd         o_cmd,
    input  wire logic              i_cmd_pop
);

    logic [mits_pkg::CNT_W-1:0]     r_count;
    logic [mits_pkg::CNT_W-1:0]     n_count;
    logic [mits_pkg::JIF_W-1:0]     r_last_jif;
    logic [mits_pkg::JIF_W-1:0]     n_last_jif;
    mits_pkg::t_cmd                 r_q [mits_pkg::CMD_DEPTH];
    logic [mits_pkg::CMD_PTR_W-1:0] r_wp;
    logic [mits_pkg::CMD_PTR_W-1:0] r_rp;
    logic [mits_pkg::CMD_CNT_W-1:0] r_qcnt;
    logic [mits_pkg::CMD_CNT_W-1:0] n_qcnt;

    logic                       accept;
    logic                       pop_q;
    logic                       q_push;
    mits_pkg::t_cmd             cmd_new;
    logic [mits_pkg::JIF_W-1:0] laps;

    assign full        = (r_qcnt == mits_pkg::CMD_CNT_W'(mits_pkg::CMD_DEPTH));
    assign o_cmd_valid = (r_qcnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign accept      = push && !full;
    assign pop_q       = i_cmd_pop && o_cmd_valid;

    always_comb begin
        // A tick at jiffies zero counts as no elapsed time.
        laps       = (i_in_item.jiffies == '0) ? '0 : (i_in_item.jiffies - r_last_jif);
        n_count    = r_count;
        n_last_jif = r_last_jif;
        q_push     = 1'b0;
        cmd_new.op       = mits_pkg::OP_TICK;
        cmd_new.index    = '0;
        cmd_new.interval = i_in_item.interval_ms;
        cmd_new.laps     = laps;
        if (accept) begin
            if (i_in_item.mode == mits_pkg::MODE_ADD) begin
                q_push = 1'b1;
                if (r_count < mits_pkg::CNT_W'(mits_pkg::MAX_TIMERS)) begin
                    cmd_new.op    = mits_pkg::OP_ADD;
                    cmd_new.index = r_count[mits_pkg::IDX_W-1:0];
                    n_count       = r_count + 1'b1;
                end else begin
                    cmd_new.op = mits_pkg::OP_FULL;
                end
            end else if (laps != '0) begin
                q_push     = 1'b1;
                n_last_jif = i_in_item.jiffies;
            end
        end
        n_qcnt = r_qcnt + mits_pkg::CMD_CNT_W'(q_push) - mits_pkg::CMD_CNT_W'(pop_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_last_jif <= '0;
            r_wp       <= '0;
            r_rp       <= '0;
            r_qcnt     <= '0;
        end else begin
            r_count    <= n_count;
            r_last_jif <= n_last_jif;
            r_qcnt     <= n_qcnt;
            if (q_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop_q) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_push) begin
            r_q[r_wp] <= cmd_new;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/mits_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mits_back
// Executes queued commands: stores new timers, scans the table on a tick
// one entry per cycle while the result queue has room, and queues the result requests.
// ----------------------------------------------------------------------------
module mits_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cmd_valid,
    input  wire mits_pkg::t_cmd i_cmd,
    output logic                o_cmd_pop,
    output logic                empty,
    input  wire logic           pop,
    output mits_pkg::t_out_item o_out_item
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } t_state;

    t_state                          r_state;
    t_state                          n_state;
    logic [mits_pkg::CNT_W-1:0]      r_count;
    logic [mits_pkg::CNT_W-1:0]      n_count;
    logic [mits_pkg::CNT_W-1:0]      r_n;
    logic [mits_pkg::CNT_W-1:0]      n_n;
    logic [mits_pkg::JIF_W-1:0]      r_laps;
    logic [mits_pkg::JIF_W-1:0]      n_laps;
    logic                            r_pend_v;
    logic                            n_pend_v;
    logic [mits_pkg::IDX_W-1:0]      r_pend_idx;
    logic [mits_pkg::IDX_W-1:0]      n_pend_idx;

    logic [mits_pkg::IVL_W-1:0]      r_ivl [mits_pkg::MAX_TIMERS];
    logic [mits_pkg::JIF_W-1:0]      r_ela [mits_pkg::MAX_TIMERS];

    mits_pkg::t_out_item             r_res [mits_pkg::RES_DEPTH];
    logic [mits_pkg::RES_PTR_W-1:0]  r_res_wp;
    logic [mits_pkg::RES_PTR_W-1:0]  r_res_rp;
    logic [mits_pkg::RES_CNT_W-1:0]  r_res_cnt;

    logic                            res_full;
    logic                            res_push;
    logic                            res_pop;
    mits_pkg::t_out_item             res_data;

    logic                            ivl_we;
    logic                            ela_we;
    logic [mits_pkg::IDX_W-1:0]      wr_idx;
    logic [mits_pkg::JIF_W-1:0]      ela_wdata;

    logic [mits_pkg::IDX_W-1:0]      scan_idx;
    logic [mits_pkg::JIF_W:0]        sum;
    logic [mits_pkg::JIF_W-1:0]      sat;
    logic                            expired;

    assign res_full   = (r_res_cnt == mits_pkg::RES_CNT_W'(mits_pkg::RES_DEPTH));
    assign empty      = (r_res_cnt == '0);
    assign res_pop    = pop && !empty;
    assign o_out_item = r_res[r_res_rp];

    assign scan_idx = r_n[mits_pkg::IDX_W-1:0];
    // The counter saturates at all ones, which always reaches the interval.
    assign sum      = {1'b0, r_ela[scan_idx]} + {1'b0, r_laps};
    assign sat      = sum[mits_pkg::JIF_W] ? '1 : sum[mits_pkg::JIF_W-1:0];
    assign expired  = (sat >= {{(mits_pkg::JIF_W - mits_pkg::IVL_W){1'b0}}, r_ivl[scan_idx]});

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_n        = r_n;
        n_laps     = r_laps;
        n_pend_v   = r_pend_v;
        n_pend_idx = r_pend_idx;
        o_cmd_pop  = 1'b0;
        res_push   = 1'b0;
        res_data.kind        = mits_pkg::KIND_EXPIRED;
        res_data.timer_index = 4'(r_pend_idx);
        res_data.last        = 1'b0;
        ivl_we     = 1'b0;
        ela_we     = 1'b0;
        wr_idx     = scan_idx;
        ela_wdata  = expired ? '0 : sat;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        mits_pkg::OP_ADD: begin
                            if (!res_full) begin
                                o_cmd_pop            = 1'b1;
                                ivl_we               = 1'b1;
                                ela_we               = 1'b1;
                                wr_idx               = i_cmd.index;
                                ela_wdata            = '0;
                                n_count              = r_count + 1'b1;
                                res_push             = 1'b1;
                                res_data.kind        = mits_pkg::KIND_ADDED;
                                res_data.timer_index = 4'(i_cmd.index);
                                res_data.last        = 1'b1;
                            end
                        end
                        mits_pkg::OP_FULL: begin
                            if (!res_full) begin
                                o_cmd_pop            = 1'b1;
                                res_push             = 1'b1;
                                res_data.kind        = mits_pkg::KIND_FULL;
                                res_data.timer_index = '0;
                                res_data.last        = 1'b1;
                            end
                        end
                        mits_pkg::OP_TICK: begin
                            o_cmd_pop = 1'b1;
                            n_laps    = i_cmd.laps;
                            n_n       = '0;
                            n_state   = S_SCAN;
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_n == r_count) begin
                    n_state = S_FLUSH;
                end else if (!res_full) begin
                    ela_we = 1'b1;
                    n_n    = r_n + 1'b1;
                    if (expired) begin
                        // The held expiry is not the final one, since another follows.
                        res_push   = r_pend_v;
                        n_pend_v   = 1'b1;
                        n_pend_idx = scan_idx;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = S_IDLE;
                end else if (!res_full) begin
                    res_push      = 1'b1;
                    res_data.last = 1'b1;
                    n_pend_v      = 1'b0;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_n        <= '0;
            r_pend_v   <= 1'b0;
            r_res_wp   <= '0;
            r_res_rp   <= '0;
            r_res_cnt  <= '0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_n        <= n_n;
            r_pend_v   <= n_pend_v;
            r_res_cnt  <= r_res_cnt + mits_pkg::RES_CNT_W'(res_push)
                          - mits_pkg::RES_CNT_W'(res_pop);
            if (res_push) begin
                r_res_wp <= r_res_wp + 1'b1;
            end
            if (res_pop) begin
                r_res_rp <= r_res_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_laps     <= n_laps;
        r_pend_idx <= n_pend_idx;
        if (ivl_we) begin
            r_ivl[wr_idx] <= i_cmd.interval;
        end
        if (ela_we) begin
            r_ela[wr_idx] <= ela_wdata;
        end
        if (res_push) begin
            r_res[r_res_wp] <= res_data;
        end
    end

endmodule
`default_nettype wire
